// ===== design/sbcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbcm_pkg;

    localparam logic [1:0] CFG_PRECOMP_GAIN = 2'd0;
    localparam logic [1:0] CFG_PEQ_GAIN     = 2'd1;
    localparam logic [1:0] CFG_PEQ_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_METER_DECAY  = 2'd3;

    localparam logic        FUNC_LOAD    = 1'b0;
    localparam logic        FUNC_PROCESS = 1'b1;

    localparam logic [31:0] RESET_PRECOMP = 32'd16777216;
    localparam logic [31:0] RESET_PEQ     = 32'd16777216;
    localparam logic [23:0] RESET_DECAY   = 24'd16760000;

    // 1.0 in Q12.52 and the largest magnitude whose reciprocal saturates.
    localparam logic [63:0] ONE_Q52       = 64'h0010_0000_0000_0000;
    localparam logic [31:0] RECIP_SAT_MAG = 32'h0010_0000;

    function automatic logic [31:0] sat_q24(input logic [63:0] p);
        sat_q24 = (p[63:56] != 8'd0) ? 32'hFFFF_FFFF : p[55:24];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] signed_part(input logic [63:0] p, input logic neg);
        logic [39:0] q;
        logic [31:0] qn;
        q = p[63:24];
        if (neg)
        begin
            qn = (q > 40'h00_8000_0000) ? 32'h8000_0000 : q[31:0];
            signed_part = 32'd0 - qn;
        end
        else
        begin
            signed_part = (q > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/spectral_bin_compressor_mask_unit.sv =====
// Per-bin gain mask of a frequency-domain compressor.
// Input channel (in_valid / in_stall): one word per item. func selects a table
// load (comp_word and peq_word stored at bin_index) or the processing of one
// spectrum bin (bin_re, bin_im). Loads and out-of-range bins give no result.
// Output channel (out_valid / out_stall): one word per processed bin with the
// masked bin, the peak meter level and the limited flag.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// write only while the block is idle.
// A load writes the table entry at bin_index. A processed bin passes through
// the square, square-root and gain steps, then the reciprocal divider when it
// is limited and its magnitude is above RECIP_SAT_MAG, a meter decay step when
// it sets no new peak, and the equalizer steps when enabled, before its result
// is registered. Processing time is set by the bit-serial square root (32 steps),
// the serial reciprocal divider (32 steps) and the single shared 32x32 multiplier that
// all products go through.
// Input is stalled while a bin is in work; the result register holds the
// last word, so the next item is taken while it waits. If the receiver still
// stalls when a new result is ready, the block waits with it.
// Reset clears the meter, restores register defaults and empties the output.
// Table entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module spectral_bin_compressor_mask_unit #(
    parameter int FRAME_SIZE = 512
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [8:0]  bin_index,
    input  wire logic [31:0] bin_re,
    input  wire logic [31:0] bin_im,
    input  wire logic [31:0] comp_word,
    input  wire logic [31:0] peq_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [8:0]       bin_number,
    output logic [31:0]      masked_re,
    output logic [31:0]      masked_im,
    output logic [31:0]      meter_level,
    output logic             limited,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import sbcm_pkg::*;

    localparam int BINS   = FRAME_SIZE / 2 + 1;
    localparam int ADDR_W = $clog2(BINS);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQRE  = 5'd1;
    localparam logic [4:0] S_SQIM  = 5'd2;
    localparam logic [4:0] S_SUM   = 5'd3;
    localparam logic [4:0] S_SQRT  = 5'd4;
    localparam logic [4:0] S_COMP  = 5'd5;
    localparam logic [4:0] S_CGAIN = 5'd6;
    localparam logic [4:0] S_TEST  = 5'd7;
    localparam logic [4:0] S_DIV   = 5'd8;
    localparam logic [4:0] S_METER = 5'd9;
    localparam logic [4:0] S_DECAY = 5'd10;
    localparam logic [4:0] S_EQG   = 5'd11;
    localparam logic [4:0] S_EQM   = 5'd12;
    localparam logic [4:0] S_EQS   = 5'd13;
    localparam logic [4:0] S_MRE   = 5'd14;
    localparam logic [4:0] S_MIM   = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [63:0] table_mem [BINS];
    logic [63:0] rd_reg;

    logic [4:0]  state_reg, state_next;
    logic [31:0] precomp_reg, peq_gain_reg;
    logic        peq_en_reg;
    logic [23:0] decay_reg;
    logic [31:0] peak_reg;

    logic [8:0]  bin_reg;
    logic [31:0] are_reg, aim_reg;
    logic        nre_reg, nim_reg;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] c_reg, mask_reg, t24_reg, re_res_reg, im_res_reg;
    logic        lim_reg;

    logic        out_valid_reg;
    logic [8:0]  out_bin_reg;
    logic [31:0] out_re_reg, out_im_reg, out_meter_reg;
    logic        out_lim_reg;

    logic        in_acc, in_range, out_free;
    logic [31:0] mul_a, mul_b;
    logic [33:0] rem_sh, trial;
    logic [32:0] drem_sh;
    logic [63:0] test_w;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign in_range  = ({23'd0, bin_index} < BINS);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign test_w    = prod_reg;

    assign rem_sh  = {rem_reg[31:0], sum_reg[63:62]};
    assign trial   = {root_reg, 2'b01};
    assign drem_sh = {rem_reg[31:0], 1'b0};

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_SQRE:  begin mul_a = are_reg; mul_b = are_reg; end
            S_SQIM:  begin mul_a = aim_reg; mul_b = aim_reg; end
            S_COMP:  begin mul_a = precomp_reg; mul_b = rd_reg[63:32]; end
            S_CGAIN: begin mul_a = sat_q24(prod_reg); mul_b = root_reg; end
            S_METER: begin mul_a = peak_reg; mul_b = {8'd0, decay_reg}; end
            S_EQG:   begin mul_a = peq_gain_reg; mul_b = rd_reg[31:0]; end
            S_EQM:   begin mul_a = mask_reg; mul_b = sat_q24(prod_reg); end
            S_MRE:   begin mul_a = are_reg; mul_b = mask_reg; end
            S_MIM:   begin mul_a = aim_reg; mul_b = mask_reg; end
            default: begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_range && func == FUNC_PROCESS)
                begin
                    state_next = S_SQRE;
                end
            end
            S_SQRE:  state_next = S_SQIM;
            S_SQIM:  state_next = S_SUM;
            S_SUM:   state_next = S_SQRT;
            S_SQRT:  state_next = (cnt_reg == 5'd0) ? S_COMP : S_SQRT;
            S_COMP:  state_next = S_CGAIN;
            S_CGAIN: state_next = S_TEST;
            S_TEST:
            begin
                if (test_w > ONE_Q52 && root_reg > RECIP_SAT_MAG)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_METER;
                end
            end
            S_DIV:   state_next = (cnt_reg == 5'd0) ? S_METER : S_DIV;
            S_METER:
            begin
                if (t24_reg > peak_reg)
                begin
                    state_next = peq_en_reg ? S_EQG : S_MRE;
                end
                else
                begin
                    state_next = S_DECAY;
                end
            end
            S_DECAY: state_next = peq_en_reg ? S_EQG : S_MRE;
            S_EQG:   state_next = S_EQM;
            S_EQM:   state_next = S_EQS;
            S_EQS:   state_next = S_MRE;
            S_MRE:   state_next = S_MIM;
            S_MIM:   state_next = S_FIN;
            S_FIN:   state_next = S_DONE;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_range && func == FUNC_LOAD)
        begin
            table_mem[ADDR_W'(bin_index)] <= {comp_word, peq_word};
        end
        if (in_acc)
        begin
            rd_reg <= table_mem[ADDR_W'(bin_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        unique case (state_reg)
            S_IDLE:
            begin
                bin_reg <= bin_index;
                are_reg <= abs32(bin_re);
                aim_reg <= abs32(bin_im);
                nre_reg <= bin_re[31];
                nim_reg <= bin_im[31];
            end
            S_SQIM:  sum_reg <= prod_reg;
            S_SUM:
            begin
                sum_reg  <= sum_reg + prod_reg;
                rem_reg  <= 34'd0;
                root_reg <= 32'd0;
                cnt_reg  <= 5'd31;
            end
            S_SQRT:
            begin
                sum_reg <= {sum_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg - 5'd1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            S_CGAIN: c_reg <= sat_q24(prod_reg);
            S_TEST:
            begin
                lim_reg  <= (test_w > ONE_Q52);
                t24_reg  <= (test_w[63:60] != 4'd0) ? 32'hFFFF_FFFF : test_w[59:28];
                mask_reg <= (test_w > ONE_Q52) ? 32'hFFFF_FFFF : c_reg;
                rem_reg  <= {2'b00, RECIP_SAT_MAG};
                cnt_reg  <= 5'd31;
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (drem_sh >= {1'b0, root_reg})
                begin
                    rem_reg  <= {2'b00, 32'(drem_sh - {1'b0, root_reg})};
                    mask_reg <= {mask_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= {2'b00, drem_sh[31:0]};
                    mask_reg <= {mask_reg[30:0], 1'b0};
                end
            end
            S_EQS:   mask_reg   <= sat_q24(prod_reg);
            S_MIM:   re_res_reg <= signed_part(prod_reg, nre_reg);
            S_FIN:   im_res_reg <= signed_part(prod_reg, nim_reg);
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            precomp_reg   <= RESET_PRECOMP;
            peq_gain_reg  <= RESET_PEQ;
            peq_en_reg    <= 1'b0;
            decay_reg     <= RESET_DECAY;
            peak_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PRECOMP_GAIN: precomp_reg  <= cfg_data;
                    CFG_PEQ_GAIN:     peq_gain_reg <= cfg_data;
                    CFG_PEQ_ENABLE:   peq_en_reg   <= cfg_data[0];
                    CFG_METER_DECAY:  decay_reg    <= cfg_data[23:0];
                    default:          begin end
                endcase
            end
            if (state_reg == S_METER && t24_reg > peak_reg)
            begin
                peak_reg <= t24_reg;
            end
            else if (state_reg == S_DECAY)
            begin
                peak_reg <= prod_reg[55:24];
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_bin_reg   <= bin_reg;
            out_re_reg    <= re_res_reg;
            out_im_reg    <= im_res_reg;
            out_meter_reg <= peak_reg;
            out_lim_reg   <= lim_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_number  = out_bin_reg;
    assign masked_re   = out_re_reg;
    assign masked_im   = out_im_reg;
    assign meter_level = out_meter_reg;
    assign limited     = out_lim_reg;

    a_busy_after_process: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_range && func == FUNC_PROCESS) |=> (state_reg == S_SQRE))
        else $error("processed bin did not start work");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("pending result overwritten");

    a_meter_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_METER && state_reg != S_DECAY) |=> $stable(peak_reg))
        else $error("meter changed outside its update");

    a_divider_only_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> lim_reg)
        else $error("reciprocal computed for an unlimited bin");

endmodule

`default_nettype wire
